// ===== hw/rtl/hcbd_pkg.sv =====
// shared types, byte codes, phase codes and helpers for the chunked body decoder
package hcbd_pkg;

  localparam int unsigned SizeBitsDefault = 32;

  // decoder phases
  localparam logic [2:0] PhWs    = 3'd0;
  localparam logic [2:0] PhHex   = 3'd1;
  localparam logic [2:0] PhExt   = 3'd2;
  localparam logic [2:0] PhLf    = 3'd3;
  localparam logic [2:0] PhData  = 3'd4;
  localparam logic [2:0] PhTail1 = 3'd5;
  localparam logic [2:0] PhTail2 = 3'd6;
  localparam logic [2:0] PhDone  = 3'd7;

  localparam logic [7:0] ByteCr    = 8'h0D;
  localparam logic [7:0] ByteSpace = 8'h20;
  localparam logic [7:0] ByteTab   = 8'h09;
  localparam logic [7:0] ByteFf    = 8'h0C;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hcbd_hex_t;

  // result of one decode step
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } hcbd_res_t;

  function automatic hcbd_hex_t hex_decode(input logic [7:0] b);
    hcbd_hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.val = 4'(b - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == ByteSpace) || (b >= ByteTab && b <= ByteFf);
  endfunction

endpackage

// ===== hw/rtl/hcbd_step.sv =====
// next-state and result logic for one body byte
module hcbd_step #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SizeBitsDefault
) (
  input  logic [2:0]           phase_i,
  input  logic [SIZE_BITS-1:0] rem_i,
  input  logic [7:0]           byte_i,
  input  logic                 start_i,
  output logic [2:0]           phase_o,
  output logic [SIZE_BITS-1:0] rem_o,
  output hcbd_pkg::hcbd_res_t  res_o
);
  import hcbd_pkg::*;

  logic [2:0]           phase;
  logic [SIZE_BITS-1:0] rem;
  logic [SIZE_BITS-1:0] rem_acc;
  logic [SIZE_BITS-1:0] rem_dec;
  hcbd_hex_t            hex;
  logic                 is_cr;

  // a start flag restarts the decoder before this byte
  assign phase = start_i ? PhWs : phase_i;
  assign rem   = start_i ? '0 : rem_i;
  assign hex   = hex_decode(byte_i);
  assign is_cr = (byte_i == ByteCr);

  // saturating shift-in of one hex digit
  assign rem_acc = (rem[SIZE_BITS-1 -: 4] != 4'd0) ? '1 : {rem[SIZE_BITS-5:0], hex.val};
  assign rem_dec = (rem != '0) ? rem - SIZE_BITS'(1) : rem;

  always_comb begin
    phase_o = phase;
    rem_o   = rem;
    res_o   = '0;
    unique case (phase)
      PhWs, PhHex, PhExt: begin
        if (is_cr) begin
          if (rem == '0) begin
            phase_o    = PhDone;
            res_o.valid = 1'b1;
            res_o.last  = 1'b1;
          end else begin
            phase_o = PhLf;
          end
        end else if (phase == PhExt) begin
          phase_o = PhExt;
        end else if (phase == PhWs && is_space(byte_i)) begin
          phase_o = PhWs;
        end else if (hex.ok) begin
          rem_o   = rem_acc;
          phase_o = PhHex;
        end else begin
          phase_o = PhExt;
        end
      end
      PhLf: begin
        phase_o = (rem != '0) ? PhData : PhTail1;
      end
      PhData: begin
        res_o.valid = 1'b1;
        res_o.data  = byte_i;
        rem_o       = rem_dec;
        if (rem_dec == '0) begin
          phase_o = PhTail1;
        end
      end
      PhTail1: begin
        phase_o = PhTail2;
      end
      PhTail2: begin
        rem_o   = '0;
        phase_o = PhWs;
      end
      default: begin
        phase_o = PhDone;
      end
    endcase
  end

endmodule

// ===== hw/rtl/http_chunked_body_decoder.sv =====
// top level of the chunked transfer body decoder
//
// usage:
//  - slave side takes the raw body one byte per beat; tuser set on a beat
//    restarts the decoder before that byte (first byte of a new body)
//  - master side gives decoded payload bytes; a beat with tlast set and
//    tdata zero is the end marker from the zero-size chunk line
//  - size lines, chunk extensions and separators give no master beat
// timing:
//  - an accepted beat lands in an input register; the decode step runs on
//    it there and loads the result register, which drives the master beat
//  - one byte per cycle unless the master side stalls; the step is a hex
//    shift-add or a remaining-count decrement plus a small phase update
// reset and stalls:
//  - reset clears both valids and puts the decoder in the leading
//    whitespace phase with a zero size
//  - while the master side stalls, the held result stays put; a byte that
//    gives no result still moves through, and one that does waits
module http_chunked_body_decoder #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SizeBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tuser_i,   // [0] body_start
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o    // end_of_body
);
  import hcbd_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  // decoder state
  logic [2:0]           phase_q;
  logic [2:0]           phase_d;
  logic [SIZE_BITS-1:0] rem_q;
  logic [SIZE_BITS-1:0] rem_d;

  // result register
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  hcbd_res_t res;
  logic      out_free;
  logic      advance;
  logic      in_ready;

  hcbd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .phase_i (phase_q),
    .rem_i   (rem_q),
    .byte_i  (in_byte_q),
    .start_i (in_start_q),
    .phase_o (phase_d),
    .rem_o   (rem_d),
    .res_o   (res)
  );

  // a beat with no result never waits on the master side
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign advance  = in_valid_q && (!res.valid || out_free);
  assign in_ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhWs;
      rem_q   <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_byte_q <= res.data;
      out_last_q <= res.last;
    end
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== hw/rtl/hcbd_checker.sv =====
// port-level checks for the chunked body decoder, bound to the top level
module hcbd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  // the end marker carries a zero byte
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o == 8'h00)
    else $error("end marker with nonzero byte");

  // with no result held, the input side is always open
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // a stalled result beat stays valid
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result payload changed while stalled");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
